>>> design/mi3_pkg.sv
package mi3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ENT_W         = 32;
    localparam int N_ENT         = 9;
    localparam int PROD_W        = 2 * ENT_W;
    localparam int COF_W         = PROD_W + 1;
    localparam int DET_W         = 97;
    localparam int QUO_W         = ENT_W + 1;

endpackage

>>> design/matrix_inverse_3x3_core.sv
// 3x3 inverse by adjugate on signed fixed-point words (FRAC_BITS fraction bits, Q16.16 by
// default). busy is held low: a new matrix can be started in every clock cycle. Each
// matrix gives one result word on the o_ ports, marked by o_strobe for a single cycle,
// in start order; the receiver cannot stall and must take it then. The pipeline is
// seven stages of products, cofactors, determinant, magnitudes and divide entry, then the
// 33-step restoring divide (one quotient bit per stage, nine lanes in parallel). A zero
// determinant gives zero entries with o_singular set; quotients outside the signed
// 32-bit range clip to it and set o_saturated.
module matrix_inverse_3x3_core #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_in_c0_r0,
    input  logic signed [31:0] i_in_c0_r1,
    input  logic signed [31:0] i_in_c0_r2,
    input  logic signed [31:0] i_in_c1_r0,
    input  logic signed [31:0] i_in_c1_r1,
    input  logic signed [31:0] i_in_c1_r2,
    input  logic signed [31:0] i_in_c2_r0,
    input  logic signed [31:0] i_in_c2_r1,
    input  logic signed [31:0] i_in_c2_r2,
    output logic               o_strobe,
    output logic signed [31:0] o_out_c0_r0,
    output logic signed [31:0] o_out_c0_r1,
    output logic signed [31:0] o_out_c0_r2,
    output logic signed [31:0] o_out_c1_r0,
    output logic signed [31:0] o_out_c1_r1,
    output logic signed [31:0] o_out_c1_r2,
    output logic signed [31:0] o_out_c2_r0,
    output logic signed [31:0] o_out_c2_r1,
    output logic signed [31:0] o_out_c2_r2,
    output logic               o_singular,
    output logic               o_saturated
);

    localparam int EW   = mi3_pkg::ENT_W;
    localparam int NE   = mi3_pkg::N_ENT;
    localparam int PW   = mi3_pkg::PROD_W;
    localparam int KW   = mi3_pkg::COF_W;
    localparam int DW   = mi3_pkg::DET_W;
    localparam int QW   = mi3_pkg::QUO_W;
    localparam int MW   = DW - 1;
    localparam int NW   = PW + 2 * FRAC_BITS;
    localparam int CW   = MW + QW;

    // cofactor operand indexes, entry index is column * 3 + row
    localparam int A0 [NE] = '{4, 7, 1, 6, 0, 2, 3, 1, 0};
    localparam int B0 [NE] = '{8, 2, 5, 5, 8, 3, 7, 6, 4};
    localparam int A1 [NE] = '{5, 1, 2, 3, 6, 0, 6, 0, 1};
    localparam int B1 [NE] = '{7, 8, 4, 8, 2, 5, 4, 7, 3};

    logic signed [EW-1:0] w_m [NE];

    assign busy   = 1'b0;
    assign w_m[0] = i_in_c0_r0;
    assign w_m[1] = i_in_c0_r1;
    assign w_m[2] = i_in_c0_r2;
    assign w_m[3] = i_in_c1_r0;
    assign w_m[4] = i_in_c1_r1;
    assign w_m[5] = i_in_c1_r2;
    assign w_m[6] = i_in_c2_r0;
    assign w_m[7] = i_in_c2_r1;
    assign w_m[8] = i_in_c2_r2;

    logic [5:0] r_v;
    logic       r_dv_v [QW+1];

    // stage 1: entry products
    logic signed [PW-1:0] r_pa [NE];
    logic signed [PW-1:0] r_pb [NE];
    logic signed [EW-1:0] r_mc1 [3];
    // stage 2: cofactors
    logic signed [KW-1:0] r_k2 [NE];
    logic signed [EW-1:0] r_mc2 [3];
    // stage 3: split determinant products
    logic signed [KW-1:0] r_k3 [NE];
    logic signed [KW-1:0] r_pl [3];
    logic signed [KW-1:0] r_ph [3];
    // stage 4: determinant terms
    logic signed [KW-1:0] r_k4 [NE];
    logic signed [DW-1:0] r_term [3];
    // stage 5: determinant
    logic signed [KW-1:0] r_k5 [NE];
    logic signed [DW-1:0] r_det;
    // stage 6: magnitudes
    logic [NW-1:0]        r_num [NE];
    logic                 r_neg6 [NE];
    logic [MW-1:0]        r_dmag6;
    logic                 r_zero6;
    // divide stages
    logic [NW-1:0]        r_rem  [QW+1][NE];
    logic [QW-1:0]        r_q    [QW+1][NE];
    logic                 r_ovf  [QW+1][NE];
    logic                 r_neg  [QW+1][NE];
    logic [MW-1:0]        r_dmag [QW+1];
    logic                 r_zero [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_v      <= {r_v[4:0], start};
            o_strobe <= r_dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < NE; e++) begin
            r_pa[e] <= w_m[A0[e]] * w_m[B0[e]];
            r_pb[e] <= w_m[A1[e]] * w_m[B1[e]];
            r_k2[e] <= KW'(r_pa[e]) - KW'(r_pb[e]);
            r_k3[e] <= r_k2[e];
            r_k4[e] <= r_k3[e];
            r_k5[e] <= r_k4[e];
        end
        for (int t = 0; t < 3; t++) begin
            r_mc1[t]  <= w_m[3 * t];
            r_mc2[t]  <= r_mc1[t];
            r_pl[t]   <= $signed({1'b0, r_k2[t][EW-1:0]}) * r_mc2[t];
            r_ph[t]   <= $signed(r_k2[t][KW-1:EW]) * r_mc2[t];
            r_term[t] <= $signed({r_ph[t], {EW{1'b0}}}) + DW'(r_pl[t]);
        end
        r_det <= r_term[0] + r_term[1] + r_term[2];
    end

    always_ff @(posedge i_clk) begin
        logic [KW-1:0] v_abs;
        logic [DW-1:0] v_dabs;
        v_dabs  = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        r_dmag6 <= v_dabs[MW-1:0];
        r_zero6 <= (r_det == '0);
        for (int e = 0; e < NE; e++) begin
            v_abs     = r_k5[e][KW-1] ? KW'(-r_k5[e]) : KW'(r_k5[e]);
            r_num[e]  <= {v_abs[PW-1:0], {(2 * FRAC_BITS){1'b0}}};
            r_neg6[e] <= r_k5[e][KW-1] ^ r_det[DW-1];
        end
    end

    // divide entry: catch quotients of more than QW bits
    always_ff @(posedge i_clk) begin
        r_dmag[0] <= r_dmag6;
        r_zero[0] <= r_zero6;
        for (int e = 0; e < NE; e++) begin
            r_rem[0][e] <= r_num[e];
            r_q[0][e]   <= '0;
            r_neg[0][e] <= r_neg6[e];
            r_ovf[0][e] <= (CW'(r_num[e]) >= (CW'(r_dmag6) << QW));
        end
    end

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_div
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_v[j+1] <= 1'b0;
                end else begin
                    r_dv_v[j+1] <= r_dv_v[j];
                end
            end

            always_ff @(posedge i_clk) begin
                logic [CW-1:0] v_trial;
                logic          v_ge;
                v_trial     = CW'(r_dmag[j]) << (QW - 1 - j);
                r_dmag[j+1] <= r_dmag[j];
                r_zero[j+1] <= r_zero[j];
                for (int e = 0; e < NE; e++) begin
                    v_ge          = (CW'(r_rem[j][e]) >= v_trial);
                    r_rem[j+1][e] <= v_ge ? NW'(CW'(r_rem[j][e]) - v_trial) : r_rem[j][e];
                    r_q[j+1][e]   <= {r_q[j][e][QW-2:0], v_ge};
                    r_ovf[j+1][e] <= r_ovf[j][e];
                    r_neg[j+1][e] <= r_neg[j][e];
                end
            end
        end
    endgenerate

    logic signed [EW-1:0] w_res [NE];
    logic                 w_sat;

    always_comb begin
        logic          v_clip;
        logic [QW-1:0] v_q;
        w_sat = 1'b0;
        for (int e = 0; e < NE; e++) begin
            v_q = r_q[QW][e];
            if (r_neg[QW][e]) begin
                v_clip   = r_ovf[QW][e] || (v_q > QW'(33'h0_8000_0000));
                w_res[e] = v_clip ? 32'sh8000_0000 : -$signed(v_q[EW-1:0]);
            end else begin
                v_clip   = r_ovf[QW][e] || v_q[QW-1] || v_q[QW-2];
                w_res[e] = v_clip ? 32'sh7FFF_FFFF : $signed(v_q[EW-1:0]);
            end
            if (r_zero[QW]) begin
                w_res[e] = '0;
                v_clip   = 1'b0;
            end
            w_sat = w_sat | v_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        o_out_c0_r0 <= w_res[0];
        o_out_c0_r1 <= w_res[1];
        o_out_c0_r2 <= w_res[2];
        o_out_c1_r0 <= w_res[3];
        o_out_c1_r1 <= w_res[4];
        o_out_c1_r2 <= w_res[5];
        o_out_c2_r0 <= w_res[6];
        o_out_c2_r1 <= w_res[7];
        o_out_c2_r2 <= w_res[8];
        o_singular  <= r_zero[QW];
        o_saturated <= w_sat;
    end

endmodule

>>> bench/tb_top.sv
module tb_top;

    typedef logic [mi3_pkg::N_ENT-1:0][mi3_pkg::ENT_W-1:0] t_mat;

    typedef struct packed {
        t_mat ent;
        logic sing;
        logic sat;
    } t_inv_word;

    localparam logic [mi3_pkg::ENT_W-1:0] ONE     = 32'h0001_0000;
    localparam logic [mi3_pkg::ENT_W-1:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [mi3_pkg::ENT_W-1:0] MAX_NEG = 32'h8000_0000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_mat mat_drv;
    logic o_strobe;
    t_mat res;
    logic o_singular;
    logic o_saturated;

    t_inv_word inverse_q[$];
    int n_mismatch;
    int n_words;

    matrix_inverse_3x3_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in_c0_r0 (mat_drv[0]),
        .i_in_c0_r1 (mat_drv[1]),
        .i_in_c0_r2 (mat_drv[2]),
        .i_in_c1_r0 (mat_drv[3]),
        .i_in_c1_r1 (mat_drv[4]),
        .i_in_c1_r2 (mat_drv[5]),
        .i_in_c2_r0 (mat_drv[6]),
        .i_in_c2_r1 (mat_drv[7]),
        .i_in_c2_r2 (mat_drv[8]),
        .o_strobe   (o_strobe),
        .o_out_c0_r0(res[0]),
        .o_out_c0_r1(res[1]),
        .o_out_c0_r2(res[2]),
        .o_out_c1_r0(res[3]),
        .o_out_c1_r1(res[4]),
        .o_out_c1_r2(res[5]),
        .o_out_c2_r0(res[6]),
        .o_out_c2_r1(res[7]),
        .o_out_c2_r2(res[8]),
        .o_singular (o_singular),
        .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // index of entry at column c, row r is c*3+r
    function automatic t_inv_word predict_inverse(t_mat m);
        logic signed [127:0] a [9];
        logic signed [127:0] k [9];
        logic signed [127:0] det;
        logic [127:0] dmag;
        logic [127:0] num;
        logic [127:0] quo;
        logic neg;
        t_inv_word w;
        for (int i = 0; i < 9; i++) begin
            a[i] = {{96{m[i][31]}}, m[i]};
        end
        k[0] = a[4] * a[8] - a[5] * a[7];
        k[3] = a[6] * a[5] - a[3] * a[8];
        k[6] = a[3] * a[7] - a[6] * a[4];
        k[1] = a[7] * a[2] - a[1] * a[8];
        k[4] = a[0] * a[8] - a[6] * a[2];
        k[7] = a[1] * a[6] - a[0] * a[7];
        k[2] = a[1] * a[5] - a[2] * a[4];
        k[5] = a[2] * a[3] - a[0] * a[5];
        k[8] = a[0] * a[4] - a[1] * a[3];
        det = k[0] * a[0] + k[1] * a[3] + k[2] * a[6];
        w = '0;
        if (det == 0) begin
            w.sing = 1'b1;
            return w;
        end
        dmag = det < 0 ? -det : det;
        for (int i = 0; i < 9; i++) begin
            neg = (k[i] < 0) != (det < 0);
            num = (k[i] < 0 ? -k[i] : k[i]);
            num = num << (2 * mi3_pkg::FRAC_BITS_DEF);
            quo = num / dmag;
            if (neg) begin
                if (quo > 128'h8000_0000) begin
                    w.ent[i] = MAX_NEG;
                    w.sat = 1'b1;
                end else begin
                    w.ent[i] = -quo[31:0];
                end
            end else begin
                if (quo > 128'h7FFF_FFFF) begin
                    w.ent[i] = MAX_POS;
                    w.sat = 1'b1;
                end else begin
                    w.ent[i] = quo[31:0];
                end
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_inv_word exp_w;
        if (i_rst_n && o_strobe) begin
            n_words++;
            if (inverse_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result word at %0t", $time);
            end else begin
                exp_w = inverse_q.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (res[i] !== exp_w.ent[i]) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("word %0d entry c%0d_r%0d: exp %h got %h",
                                     n_words, i / 3, i % 3, exp_w.ent[i], res[i]);
                    end
                end
                if (o_singular !== exp_w.sing || o_saturated !== exp_w.sat) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("word %0d flags sing/sat: exp %b%b got %b%b",
                                 n_words, exp_w.sing, exp_w.sat, o_singular, o_saturated);
                end
            end
        end
    end

    task automatic idle_gap();
        int n;
        int p;
        p = $urandom_range(99);
        if (p < 60) n = 0;
        else if (p < 95) n = $urandom_range(3, 1);
        else n = $urandom_range(60, 10);
        if (n > 0) begin
            start = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // called at a falling edge, returns at a falling edge after any idle gap
    task automatic send_matrix(input t_mat m);
        start = 1'b1;
        mat_drv = m;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        inverse_q.push_back(predict_inverse(m));
        @(negedge i_clk);
        idle_gap();
    endtask

    task automatic drain();
        start = 1'b0;
        while (inverse_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_mat diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
        t_mat m;
        m = '0;
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
        return m;
    endfunction

    function automatic t_mat rand_small();
        t_mat m;
        for (int i = 0; i < 9; i++) m[i] = $urandom_range(ONE * 8) - ONE * 4;
        return m;
    endfunction

    function automatic t_mat rand_full();
        t_mat m;
        for (int i = 0; i < 9; i++) m[i] = $urandom;
        return m;
    endfunction

    task automatic test_directed();
        t_mat m;
        send_matrix(diag(ONE, ONE, ONE));
        send_matrix(diag(ONE * 2, ONE * 4, -ONE));
        send_matrix('0);
        send_matrix(diag(MAX_POS, MAX_POS, MAX_POS));
        send_matrix(diag(MAX_NEG, MAX_NEG, MAX_NEG));
        send_matrix(diag(32'd1, 32'd1, 32'd1));
        send_matrix(diag(MAX_NEG, 32'd1, 32'd1));
        send_matrix(diag(-32'sd1, ONE, ONE));
        send_matrix(diag(32'd1, ONE, ONE));
        send_matrix({mi3_pkg::N_ENT{MAX_POS}});
        send_matrix({mi3_pkg::N_ENT{MAX_NEG}});
        send_matrix({mi3_pkg::N_ENT{32'hFFFF_FFFF}});
        m = {mi3_pkg::N_ENT{MAX_NEG}};
        m[4] = MAX_POS;
        send_matrix(m);
        // quotient of exactly -2^31 is not clipped
        send_matrix(diag(-32'sd2, ONE, ONE));
        // permutation matrix
        m = '0;
        m[1] = ONE;
        m[5] = ONE;
        m[6] = ONE;
        send_matrix(m);
        // dependent rows
        m = rand_small();
        m[1] = m[0];
        m[4] = m[3];
        m[7] = m[6];
        send_matrix(m);
    endtask

    task automatic test_random();
        t_mat m;
        int p;
        for (int n = 0; n < 730; n++) begin
            p = $urandom_range(99);
            if (p < 50) m = rand_small();
            else if (p < 75) m = rand_full();
            else if (p < 85) begin
                // singular by a zero or repeated column
                m = $urandom_range(1) ? rand_small() : rand_full();
                m[8:6] = $urandom_range(1) ? m[2:0] : '0;
            end else if (p < 95) begin
                // near-singular, likely to clip
                m = rand_small();
                m[8:6] = m[2:0];
                m[6] = m[6] + $urandom_range(2) - 1;
            end else begin
                m = diag($urandom, $urandom, $urandom);
            end
            send_matrix(m);
            if (n == 300) drain();
        end
    endtask

    initial begin
        n_mismatch = 0;
        n_words = 0;
        start = 1'b0;
        mat_drv = '0;
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random();
        drain();
        repeat (60) @(negedge i_clk);
        if (n_mismatch == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
design/mi3_pkg.sv
design/matrix_inverse_3x3_core.sv
bench/tb_top.sv
